FILE: hdl/lcdt_pkg.sv
// Shared types, register map and timing constants for the LCD mode timing block.
// Used by lcdt_step, the top level lcd_mode_timing_registers and lcdt_checker.
`default_nettype none

package lcdt_pkg;

    // Line timing in dot clocks
    localparam logic [8:0] SEARCH_CYCLES   = 9'd80;
    localparam logic [8:0] TRANSFER_CYCLES = 9'd172;
    localparam logic [8:0] HBLANK_CYCLES   = 9'd204;
    localparam logic [8:0] LINE_CYCLES     = 9'd456;
    localparam logic [7:0] VISIBLE_LINES   = 8'd144;
    localparam logic [7:0] TOTAL_LINES     = 8'd154;

    localparam logic [15:0] CLOCK_MAX      = 16'hFFFF;

    // Control and status bits
    localparam logic [7:0] STAT_MODE_CLEAR = 8'hFC;
    localparam logic [7:0] STAT_WR_MASK    = 8'h78;
    localparam logic [7:0] STAT_WR_KEEP    = 8'h07;
    localparam logic [7:0] STAT_MATCH      = 8'h04;
    localparam logic [7:0] STAT_MATCH_IE   = 8'h40;
    localparam logic [7:0] STAT_READ_SET   = 8'h80;
    localparam logic [7:0] CTRL_ENABLE     = 8'h80;
    localparam logic [7:0] UNMAPPED_DATA   = 8'hFF;

    localparam int unsigned ITEM_TDATA_W   = 32;
    localparam int unsigned ITEM_TUSER_W   = 3;
    localparam int unsigned RES_TDATA_W    = 24;

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_READ        = 3'd1,
        CMD_WRITE       = 3'd2,
        CMD_TAKE_VBLANK = 3'd3,
        CMD_TAKE_LCD    = 3'd4
    } t_cmd;

    typedef enum logic [15:0] {
        ADDR_LCDC = 16'hFF40,
        ADDR_STAT = 16'hFF41,
        ADDR_SCY  = 16'hFF42,
        ADDR_SCX  = 16'hFF43,
        ADDR_LY   = 16'hFF44,
        ADDR_LYC  = 16'hFF45,
        ADDR_DMA  = 16'hFF46,
        ADDR_BGP  = 16'hFF47,
        ADDR_OBP0 = 16'hFF48,
        ADDR_OBP1 = 16'hFF49,
        ADDR_WY   = 16'hFF4A,
        ADDR_WX   = 16'hFF4B
    } t_addr;

    typedef enum logic [3:0] {
        MODE_HBLANK   = 4'b0001,
        MODE_VBLANK   = 4'b0010,
        MODE_SEARCH   = 4'b0100,
        MODE_TRANSFER = 4'b1000
    } t_line_mode;

    typedef struct packed {
        logic [15:0] mode_clock;
        t_line_mode  line_mode;
        logic [7:0]  line_count;
        logic [7:0]  lcd_control;
        logic [7:0]  lcd_status;
        logic [7:0]  scroll_y;
        logic [7:0]  scroll_x;
        logic [7:0]  line_compare;
        logic [7:0]  bg_palette;
        logic [7:0]  obj_palette_zero;
        logic [7:0]  obj_palette_one;
        logic [7:0]  window_y;
        logic [7:0]  window_x;
        logic [7:0]  dma_source;
        logic        vblank_pending;
        logic        lcd_pending;
    } t_lcd_state;

    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  cycles;
        logic [15:0] address;
        logic [7:0]  write_value;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_taken;
        logic [1:0] current_mode;
        logic [7:0] current_line;
    } t_result;

    // Status/bus encoding of the one-hot line mode
    function automatic logic [1:0] mode_code(input t_line_mode m);
        logic [1:0] c;
        c = 2'd0;
        unique case (m)
            MODE_HBLANK:   c = 2'd0;
            MODE_VBLANK:   c = 2'd1;
            MODE_SEARCH:   c = 2'd2;
            MODE_TRANSFER: c = 2'd3;
            default:       c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lcdt_step.sv
// Next-state and result logic for one command of the LCD mode timing block.
// Purely combinational; state is held by the top level. Uses lcdt_pkg.
`default_nettype none

module lcdt_step (
    input  var lcdt_pkg::t_lcd_state i_state,
    input  var lcdt_pkg::t_item      i_item,
    output lcdt_pkg::t_lcd_state     o_state,
    output lcdt_pkg::t_result        o_result
);

    always_comb begin
        lcdt_pkg::t_lcd_state nxt;
        logic [16:0] sum;
        logic [15:0] clk_sat;
        logic [7:0]  line_inc;
        logic [7:0]  rd;
        logic        taken;

        nxt      = i_state;
        rd       = 8'd0;
        taken    = 1'b0;
        sum      = {1'b0, i_state.mode_clock} + {10'd0, i_item.cycles};
        clk_sat  = sum[16] ? lcdt_pkg::CLOCK_MAX : sum[15:0];
        line_inc = i_state.line_count + 8'd1;

        unique case (i_item.command)
            lcdt_pkg::CMD_TICK: begin
                if ((i_state.lcd_control & lcdt_pkg::CTRL_ENABLE) == 8'd0) begin
                    nxt.line_count = 8'd0;
                    nxt.line_mode  = lcdt_pkg::MODE_HBLANK;
                    nxt.mode_clock = 16'd0;
                end else begin
                    nxt.mode_clock = clk_sat;
                    // at most one mode transition per tick
                    unique case (i_state.line_mode)
                        lcdt_pkg::MODE_SEARCH: begin
                            if (clk_sat >= {7'd0, lcdt_pkg::SEARCH_CYCLES}) begin
                                nxt.mode_clock = clk_sat - {7'd0, lcdt_pkg::SEARCH_CYCLES};
                                nxt.line_mode  = lcdt_pkg::MODE_TRANSFER;
                            end
                        end
                        lcdt_pkg::MODE_TRANSFER: begin
                            if (clk_sat >= {7'd0, lcdt_pkg::TRANSFER_CYCLES}) begin
                                nxt.mode_clock = clk_sat - {7'd0, lcdt_pkg::TRANSFER_CYCLES};
                                nxt.line_mode  = lcdt_pkg::MODE_HBLANK;
                            end
                        end
                        lcdt_pkg::MODE_HBLANK: begin
                            if (clk_sat >= {7'd0, lcdt_pkg::HBLANK_CYCLES}) begin
                                nxt.mode_clock = clk_sat - {7'd0, lcdt_pkg::HBLANK_CYCLES};
                                nxt.line_count = line_inc;
                                if (line_inc == lcdt_pkg::VISIBLE_LINES) begin
                                    nxt.line_mode      = lcdt_pkg::MODE_VBLANK;
                                    nxt.vblank_pending = 1'b1;
                                end else begin
                                    nxt.line_mode = lcdt_pkg::MODE_SEARCH;
                                end
                            end
                        end
                        default: begin
                            // vblank: whole lines until the frame wraps
                            if (clk_sat >= {7'd0, lcdt_pkg::LINE_CYCLES}) begin
                                nxt.mode_clock = clk_sat - {7'd0, lcdt_pkg::LINE_CYCLES};
                                if (line_inc >= lcdt_pkg::TOTAL_LINES) begin
                                    nxt.line_count = 8'd0;
                                    nxt.line_mode  = lcdt_pkg::MODE_SEARCH;
                                end else begin
                                    nxt.line_count = line_inc;
                                end
                            end
                        end
                    endcase

                    nxt.lcd_status = (i_state.lcd_status & lcdt_pkg::STAT_MODE_CLEAR)
                                   | {6'd0, lcdt_pkg::mode_code(nxt.line_mode)};
                    if (nxt.line_count == i_state.line_compare) begin
                        nxt.lcd_status = nxt.lcd_status | lcdt_pkg::STAT_MATCH;
                        if ((nxt.lcd_status & lcdt_pkg::STAT_MATCH_IE) != 8'd0) begin
                            nxt.lcd_pending = 1'b1;
                        end
                    end else begin
                        nxt.lcd_status = nxt.lcd_status & ~lcdt_pkg::STAT_MATCH;
                    end
                end
            end
            lcdt_pkg::CMD_READ: begin
                unique case (i_item.address)
                    lcdt_pkg::ADDR_LCDC: rd = i_state.lcd_control;
                    lcdt_pkg::ADDR_STAT: rd = i_state.lcd_status | lcdt_pkg::STAT_READ_SET;
                    lcdt_pkg::ADDR_SCY:  rd = i_state.scroll_y;
                    lcdt_pkg::ADDR_SCX:  rd = i_state.scroll_x;
                    lcdt_pkg::ADDR_LY:   rd = i_state.line_count;
                    lcdt_pkg::ADDR_LYC:  rd = i_state.line_compare;
                    lcdt_pkg::ADDR_DMA:  rd = i_state.dma_source;
                    lcdt_pkg::ADDR_BGP:  rd = i_state.bg_palette;
                    lcdt_pkg::ADDR_OBP0: rd = i_state.obj_palette_zero;
                    lcdt_pkg::ADDR_OBP1: rd = i_state.obj_palette_one;
                    lcdt_pkg::ADDR_WY:   rd = i_state.window_y;
                    lcdt_pkg::ADDR_WX:   rd = i_state.window_x;
                    default:             rd = lcdt_pkg::UNMAPPED_DATA;
                endcase
            end
            lcdt_pkg::CMD_WRITE: begin
                unique case (i_item.address)
                    lcdt_pkg::ADDR_LCDC: nxt.lcd_control = i_item.write_value;
                    lcdt_pkg::ADDR_STAT: begin
                        nxt.lcd_status = (i_state.lcd_status & lcdt_pkg::STAT_WR_KEEP)
                                       | (i_item.write_value & lcdt_pkg::STAT_WR_MASK);
                    end
                    lcdt_pkg::ADDR_SCY:  nxt.scroll_y = i_item.write_value;
                    lcdt_pkg::ADDR_SCX:  nxt.scroll_x = i_item.write_value;
                    lcdt_pkg::ADDR_LY:   nxt.line_count = 8'd0;
                    lcdt_pkg::ADDR_LYC:  nxt.line_compare = i_item.write_value;
                    lcdt_pkg::ADDR_DMA:  nxt.dma_source = i_item.write_value;
                    lcdt_pkg::ADDR_BGP:  nxt.bg_palette = i_item.write_value;
                    lcdt_pkg::ADDR_OBP0: nxt.obj_palette_zero = i_item.write_value;
                    lcdt_pkg::ADDR_OBP1: nxt.obj_palette_one = i_item.write_value;
                    lcdt_pkg::ADDR_WY:   nxt.window_y = i_item.write_value;
                    lcdt_pkg::ADDR_WX:   nxt.window_x = i_item.write_value;
                    default: ;
                endcase
                // status, line and compare writes re-check the line compare
                if ((i_item.address == lcdt_pkg::ADDR_STAT
                     || i_item.address == lcdt_pkg::ADDR_LY
                     || i_item.address == lcdt_pkg::ADDR_LYC)
                    && (nxt.lcd_status & lcdt_pkg::STAT_MATCH_IE) != 8'd0
                    && nxt.line_count == nxt.line_compare) begin
                    nxt.lcd_pending = 1'b1;
                end
            end
            lcdt_pkg::CMD_TAKE_VBLANK: begin
                taken              = i_state.vblank_pending;
                nxt.vblank_pending = 1'b0;
            end
            lcdt_pkg::CMD_TAKE_LCD: begin
                taken           = i_state.lcd_pending;
                nxt.lcd_pending = 1'b0;
            end
            default: ;
        endcase

        o_state                = nxt;
        o_result.read_data     = rd;
        o_result.irq_taken     = taken;
        o_result.current_mode  = lcdt_pkg::mode_code(nxt.line_mode);
        o_result.current_line  = nxt.line_count;
    end

endmodule

`default_nettype wire

FILE: hdl/lcd_mode_timing_registers.sv
// A result is valid on o_m_* in the cycle after its command is accepted
// when the result register is free; a stalled result delays the next by the stall.
// Throughput: one command per cycle while o_s_tready is high; the state register
// updates on accept, so back-to-back commands see each other's effects without stalls.
// A two-entry result buffer keeps o_s_tready high while one result is stalled.
// Reset (synchronous, active low) clears all registers, flags, the line
// machine and the result buffer. Uses lcdt_pkg and lcdt_step.
`default_nettype none

module lcd_mode_timing_registers (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // [6:0] cycles, [22:7] address, [30:23] write_value, [31] zero
    input  wire  [lcdt_pkg::ITEM_TDATA_W-1:0]   i_s_tdata,
    // [2:0] command
    input  wire  [lcdt_pkg::ITEM_TUSER_W-1:0]   i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // [7:0] read_data, [8] irq_taken, [10:9] current_mode,
    // [18:11] current_line, [23:19] zero
    output logic [lcdt_pkg::RES_TDATA_W-1:0]    o_m_tdata
);

    lcdt_pkg::t_lcd_state r_state;
    lcdt_pkg::t_lcd_state n_state;
    lcdt_pkg::t_item      item;
    lcdt_pkg::t_result    step_result;

    logic                 r_out_valid;
    logic                 n_out_valid;
    lcdt_pkg::t_result    r_out;
    lcdt_pkg::t_result    n_out;
    logic                 r_skid_valid;
    logic                 n_skid_valid;
    lcdt_pkg::t_result    r_skid;
    lcdt_pkg::t_result    n_skid;

    logic                 accept;
    logic                 out_free;
    lcdt_pkg::t_lcd_state step_state;

    assign item.command     = i_s_tuser[2:0];
    assign item.cycles      = i_s_tdata[6:0];
    assign item.address     = i_s_tdata[22:7];
    assign item.write_value = i_s_tdata[30:23];

    lcdt_step u_step (
        .i_state  (r_state),
        .i_item   (item),
        .o_state  (step_state),
        .o_result (step_result)
    );

    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        n_state      = accept ? step_state : r_state;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_free) begin
            // drain the skid entry first so results stay in order
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = accept;
                n_out       = step_result;
            end
        end else if (accept) begin
            n_skid_valid = 1'b1;
            n_skid       = step_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '{line_mode: lcdt_pkg::MODE_HBLANK, default: '0};
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out.current_line, r_out.current_mode,
                         r_out.irq_taken, r_out.read_data};

endmodule

`default_nettype wire

FILE: hdl/lcdt_checker.sv
// Port-level checks for lcd_mode_timing_registers, attached with bind.
// Depends on lcdt_pkg for bus widths and the frame length.
`default_nettype none

module lcdt_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                o_s_tready,
    input wire                                o_m_tvalid,
    input wire                                i_m_tready,
    input wire [lcdt_pkg::RES_TDATA_W-1:0]    o_m_tdata
);

    // hold a stalled word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // the input side only stalls when the result buffer is full
    a_ready_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no result pending");

    // a taken flag never comes with read data
    a_taken_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[8] |-> o_m_tdata[7:0] == 8'd0)
        else $error("irq_taken together with nonzero read_data");

    // line counter stays inside the frame
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[18:11] < lcdt_pkg::TOTAL_LINES)
        else $error("current_line beyond frame");

endmodule

bind lcd_mode_timing_registers lcdt_checker u_lcdt_checker (.*);

`default_nettype wire

FILE: bench/tb_lcd_mode_timing_registers.sv
// Self-checking bench for lcd_mode_timing_registers: drives command words on the
// slave stream, predicts every reply word and compares it field by field.
// Depends on lcdt_pkg for the command codes, register map and timing constants.
`default_nettype none

module tb_lcd_mode_timing_registers;
    timeunit 1ns;
    timeprecision 1ps;

    // Command codes the block treats as no-ops
    localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
    localparam logic [2:0] CMD_RESERVED_HI = 3'd7;

    // Line mode as it shows up in the status register and on the reply bus
    localparam logic [1:0] LM_HBLANK   = 2'd0;
    localparam logic [1:0] LM_VBLANK   = 2'd1;
    localparam logic [1:0] LM_SEARCH   = 2'd2;
    localparam logic [1:0] LM_TRANSFER = 2'd3;

    localparam int unsigned ERR_PRINT_MAX = 40;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              o_s_tready;
    lcdt_pkg::t_item                   cur_item = '0;
    logic                              o_m_tvalid;
    logic                              m_ready = 1'b0;
    logic [lcdt_pkg::RES_TDATA_W-1:0]  o_m_tdata;

    logic                    quiet_tail = 1'b0;
    int unsigned             gap_left = 0;
    int unsigned             stall_left = 0;
    int unsigned             error_count = 0;
    int unsigned             frame_wraps = 0;

    lcdt_pkg::t_item         command_queue[$];
    lcdt_pkg::t_result       bus_replies[$];

    // Predicted block state
    logic [15:0] p_clock;
    logic [1:0]  p_mode;
    logic [7:0]  p_line;
    logic [7:0]  r_lcdc, r_stat, r_scy, r_scx, r_lyc, r_bgp;
    logic [7:0]  r_obp0, r_obp1, r_wy, r_wx, r_dma;
    logic        vblank_flag, lcd_flag;

    always #2 clk = ~clk;

    lcd_mode_timing_registers dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        // [6:0] cycles, [22:7] address, [30:23] write_value, [31] zero
        .i_s_tdata  ({1'b0, cur_item.write_value, cur_item.address, cur_item.cycles}),
        // [2:0] command
        .i_s_tuser  (cur_item.command),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        // [7:0] read_data, [8] irq_taken, [10:9] current_mode,
        // [18:11] current_line, [23:19] zero
        .o_m_tdata  (o_m_tdata)
    );

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= ERR_PRINT_MAX)
            $display("ERROR @%0t ns: %s", $time, msg);
    endtask

    function automatic void clear_lcd_state();
        p_clock = '0;
        p_mode = LM_HBLANK;
        p_line = '0;
        {r_lcdc, r_stat, r_scy, r_scx, r_lyc, r_bgp} = '0;
        {r_obp0, r_obp1, r_wy, r_wx, r_dma} = '0;
        vblank_flag = 1'b0;
        lcd_flag = 1'b0;
    endfunction

    function automatic void compare_line_irq();
        if ((r_stat & lcdt_pkg::STAT_MATCH_IE) != 0 && p_line == r_lyc)
            lcd_flag = 1'b1;
    endfunction

    function automatic void advance_line_timing(input logic [6:0] cyc);
        int unsigned sum;
        if ((r_lcdc & lcdt_pkg::CTRL_ENABLE) == 0) begin
            p_line = '0;
            p_mode = LM_HBLANK;
            p_clock = '0;
            return;
        end
        sum = p_clock + cyc;
        if (sum > lcdt_pkg::CLOCK_MAX)
            sum = lcdt_pkg::CLOCK_MAX;
        // one transition at most per tick
        case (p_mode)
            LM_SEARCH: begin
                if (sum >= lcdt_pkg::SEARCH_CYCLES) begin
                    sum -= lcdt_pkg::SEARCH_CYCLES;
                    p_mode = LM_TRANSFER;
                end
            end
            LM_TRANSFER: begin
                if (sum >= lcdt_pkg::TRANSFER_CYCLES) begin
                    sum -= lcdt_pkg::TRANSFER_CYCLES;
                    p_mode = LM_HBLANK;
                end
            end
            LM_HBLANK: begin
                if (sum >= lcdt_pkg::HBLANK_CYCLES) begin
                    sum -= lcdt_pkg::HBLANK_CYCLES;
                    p_line = p_line + 8'd1;
                    if (p_line == lcdt_pkg::VISIBLE_LINES) begin
                        p_mode = LM_VBLANK;
                        vblank_flag = 1'b1;
                    end else begin
                        p_mode = LM_SEARCH;
                    end
                end
            end
            default: begin
                if (sum >= lcdt_pkg::LINE_CYCLES) begin
                    sum -= lcdt_pkg::LINE_CYCLES;
                    p_line = p_line + 8'd1;
                    if (p_line >= lcdt_pkg::TOTAL_LINES) begin
                        p_line = '0;
                        p_mode = LM_SEARCH;
                        frame_wraps++;
                    end
                end
            end
        endcase
        p_clock = sum[15:0];
        r_stat = (r_stat & lcdt_pkg::STAT_MODE_CLEAR) | {6'd0, p_mode};
        if (p_line == r_lyc) begin
            r_stat = r_stat | lcdt_pkg::STAT_MATCH;
            if ((r_stat & lcdt_pkg::STAT_MATCH_IE) != 0)
                lcd_flag = 1'b1;
        end else begin
            r_stat = r_stat & ~lcdt_pkg::STAT_MATCH;
        end
    endfunction

    function automatic logic [7:0] read_lcd_reg(input logic [15:0] adr);
        case (adr)
            lcdt_pkg::ADDR_LCDC: return r_lcdc;
            lcdt_pkg::ADDR_STAT: return r_stat | lcdt_pkg::STAT_READ_SET;
            lcdt_pkg::ADDR_SCY:  return r_scy;
            lcdt_pkg::ADDR_SCX:  return r_scx;
            lcdt_pkg::ADDR_LY:   return p_line;
            lcdt_pkg::ADDR_LYC:  return r_lyc;
            lcdt_pkg::ADDR_DMA:  return r_dma;
            lcdt_pkg::ADDR_BGP:  return r_bgp;
            lcdt_pkg::ADDR_OBP0: return r_obp0;
            lcdt_pkg::ADDR_OBP1: return r_obp1;
            lcdt_pkg::ADDR_WY:   return r_wy;
            lcdt_pkg::ADDR_WX:   return r_wx;
            default:             return lcdt_pkg::UNMAPPED_DATA;
        endcase
    endfunction

    function automatic void write_lcd_reg(input logic [15:0] adr, input logic [7:0] val);
        case (adr)
            lcdt_pkg::ADDR_LCDC: r_lcdc = val;
            lcdt_pkg::ADDR_STAT: begin
                r_stat = (r_stat & lcdt_pkg::STAT_WR_KEEP) | (val & lcdt_pkg::STAT_WR_MASK);
                compare_line_irq();
            end
            lcdt_pkg::ADDR_SCY:  r_scy = val;
            lcdt_pkg::ADDR_SCX:  r_scx = val;
            lcdt_pkg::ADDR_LY: begin
                p_line = '0;
                compare_line_irq();
            end
            lcdt_pkg::ADDR_LYC: begin
                r_lyc = val;
                compare_line_irq();
            end
            lcdt_pkg::ADDR_DMA:  r_dma = val;
            lcdt_pkg::ADDR_BGP:  r_bgp = val;
            lcdt_pkg::ADDR_OBP0: r_obp0 = val;
            lcdt_pkg::ADDR_OBP1: r_obp1 = val;
            lcdt_pkg::ADDR_WY:   r_wy = val;
            lcdt_pkg::ADDR_WX:   r_wx = val;
            default: ;
        endcase
    endfunction

    // Run one accepted command through the state and queue the reply it produces
    function automatic void apply_lcd_command(input lcdt_pkg::t_item it);
        lcdt_pkg::t_result rep;
        rep = '0;
        case (it.command)
            lcdt_pkg::CMD_TICK:  advance_line_timing(it.cycles);
            lcdt_pkg::CMD_READ:  rep.read_data = read_lcd_reg(it.address);
            lcdt_pkg::CMD_WRITE: write_lcd_reg(it.address, it.write_value);
            lcdt_pkg::CMD_TAKE_VBLANK: begin
                rep.irq_taken = vblank_flag;
                vblank_flag = 1'b0;
            end
            lcdt_pkg::CMD_TAKE_LCD: begin
                rep.irq_taken = lcd_flag;
                lcd_flag = 1'b0;
            end
            default: ;
        endcase
        rep.current_mode = p_mode;
        rep.current_line = p_line;
        bus_replies.push_back(rep);
    endfunction

    task automatic check_reply(input logic [lcdt_pkg::RES_TDATA_W-1:0] word);
        lcdt_pkg::t_result want;
        if (bus_replies.size() == 0) begin
            report_mismatch($sformatf("reply word %06h with nothing outstanding", word));
            return;
        end
        want = bus_replies.pop_front();
        if (word[7:0] != want.read_data)
            report_mismatch($sformatf("read_data %02h, want %02h", word[7:0], want.read_data));
        if (word[8] != want.irq_taken)
            report_mismatch($sformatf("irq_taken %0b, want %0b", word[8], want.irq_taken));
        if (word[10:9] != want.current_mode)
            report_mismatch($sformatf("current_mode %0d, want %0d",
                                      word[10:9], want.current_mode));
        if (word[18:11] != want.current_line)
            report_mismatch($sformatf("current_line %0d, want %0d",
                                      word[18:11], want.current_line));
    endtask

    // Driver: present queued command words, predict each one as it is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
            cur_item <= '0;
            gap_left <= 0;
            clear_lcd_state();
        end else begin
            if (s_valid && o_s_tready)
                apply_lcd_command(cur_item);
            if (!s_valid || o_s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
                    gap_left <= $urandom_range(0, 13);
                    s_valid <= 1'b0;
                end else if (command_queue.size() != 0) begin
                    cur_item <= command_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: take reply words with random backpressure
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_m_tvalid && m_ready)
                check_reply(o_m_tdata);
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
                stall_left <= $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic lcdt_pkg::t_item make_item(input logic [2:0] cmd,
                                                  input logic [6:0] cyc,
                                                  input logic [15:0] adr,
                                                  input logic [7:0] val);
        lcdt_pkg::t_item it;
        it.command = cmd;
        it.cycles = cyc;
        it.address = adr;
        it.write_value = val;
        return it;
    endfunction

    function automatic lcdt_pkg::t_item random_command();
        lcdt_pkg::t_item it;
        int unsigned pick;
        logic [15:0] adr;
        pick = $urandom_range(0, 99);
        adr = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                          : 16'(lcdt_pkg::ADDR_LCDC + $urandom_range(0, 11));
        it = make_item(lcdt_pkg::CMD_TICK, 7'($urandom), adr, 8'($urandom));
        if (pick < 50) begin
            it.cycles = ($urandom_range(0, 6) == 0) ? 7'($urandom_range(65, 127))
                                                    : 7'($urandom_range(0, 64));
        end else if (pick < 68) begin
            it.command = lcdt_pkg::CMD_READ;
        end else if (pick < 83) begin
            it.command = lcdt_pkg::CMD_WRITE;
            // keep the display running most of the time
            if (adr == lcdt_pkg::ADDR_LCDC && $urandom_range(0, 4) != 0)
                it.write_value = it.write_value | lcdt_pkg::CTRL_ENABLE;
            if (adr == lcdt_pkg::ADDR_LYC && $urandom_range(0, 3) != 0)
                it.write_value = 8'($urandom_range(0, lcdt_pkg::TOTAL_LINES - 1));
        end else if (pick < 95) begin
            it.command = $urandom_range(0, 1) ? lcdt_pkg::CMD_TAKE_VBLANK
                                              : lcdt_pkg::CMD_TAKE_LCD;
        end else begin
            it.command = 3'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
        end
        return it;
    endfunction

    // Mostly long ticks so a whole frame fits in a few hundred words
    function automatic lcdt_pkg::t_item frame_sweep_command();
        lcdt_pkg::t_item it;
        it = make_item(lcdt_pkg::CMD_TICK, 7'($urandom_range(120, 127)), 16'($urandom),
                       8'($urandom));
        case ($urandom_range(0, 49))
            0: it = make_item(lcdt_pkg::CMD_READ, it.cycles, lcdt_pkg::ADDR_LY,
                              it.write_value);
            1: it = make_item(lcdt_pkg::CMD_READ, it.cycles, lcdt_pkg::ADDR_STAT,
                              it.write_value);
            2: it.command = lcdt_pkg::CMD_TAKE_VBLANK;
            3: it.command = lcdt_pkg::CMD_TAKE_LCD;
            default: ;
        endcase
        return it;
    endfunction

    task automatic wait_queue_empty();
        while (command_queue.size() != 0 || s_valid)
            @(negedge clk);
    endtask

    task automatic wait_replies_done();
        wait_queue_empty();
        while (bus_replies.size() != 0)
            @(negedge clk);
    endtask

    initial begin
        int unsigned wraps_at_start;
        int unsigned chunk;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // status and flags out of reset, reserved commands, disabled tick
        command_queue.push_back(make_item(lcdt_pkg::CMD_READ, 7'd0, lcdt_pkg::ADDR_STAT,
                                          8'h00));
        command_queue.push_back(make_item(lcdt_pkg::CMD_TAKE_VBLANK, 7'd0, 16'h0000, 8'h00));
        command_queue.push_back(make_item(lcdt_pkg::CMD_TAKE_LCD, 7'd0, 16'h0000, 8'h00));
        command_queue.push_back(make_item(CMD_RESERVED_LO, 7'h7F, lcdt_pkg::ADDR_LCDC, 8'hFF));
        command_queue.push_back(make_item(lcdt_pkg::CMD_TICK, 7'h7F, 16'hFFFF, 8'hFF));
        // plain registers, some at the extremes
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_SCY, 8'hFF));
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_SCX, 8'h00));
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_DMA, 8'hA5));
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_BGP, 8'h5A));
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_OBP0,
                                          8'hFF));
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_OBP1,
                                          8'h00));
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_WY, 8'h90));
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_WX, 8'h07));
        // compare match raised by status and line writes after a compare write
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_LYC, 8'h00));
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_STAT,
                                          8'hFF));
        command_queue.push_back(make_item(lcdt_pkg::CMD_TAKE_LCD, 7'd0, 16'h0000, 8'h00));
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_LY, 8'hFF));
        // unmapped addresses
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, 16'h0000, 8'hFF));
        command_queue.push_back(make_item(lcdt_pkg::CMD_READ, 7'd0, 16'hFFFF, 8'h00));
        command_queue.push_back(make_item(lcdt_pkg::CMD_READ, 7'd0, 16'hFF4C, 8'h00));
        // enable and tick
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_LCDC,
                                          8'hFF));
        command_queue.push_back(make_item(lcdt_pkg::CMD_TICK, 7'd0, 16'h0000, 8'h00));
        command_queue.push_back(make_item(lcdt_pkg::CMD_TICK, 7'd64, 16'h0000, 8'h00));
        command_queue.push_back(make_item(lcdt_pkg::CMD_TICK, 7'h7F, 16'h0000, 8'h00));
        command_queue.push_back(make_item(lcdt_pkg::CMD_READ, 7'd0, lcdt_pkg::ADDR_LY, 8'h00));
        command_queue.push_back(make_item(lcdt_pkg::CMD_READ, 7'd0, lcdt_pkg::ADDR_STAT,
                                          8'h00));

        // hold the sender until every reply is back
        wait_replies_done();

        repeat (200) command_queue.push_back(random_command());
        wait_queue_empty();

        // sweep through vblank until the frame wraps to line 0, for at most 16 chunks
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_STAT,
                                          lcdt_pkg::STAT_MATCH_IE));
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_LYC,
                                          8'($urandom_range(0, lcdt_pkg::TOTAL_LINES - 1))));
        command_queue.push_back(make_item(lcdt_pkg::CMD_WRITE, 7'd0, lcdt_pkg::ADDR_LCDC,
                                          8'h91));
        wait_queue_empty();
        wraps_at_start = frame_wraps;
        for (chunk = 0; chunk < 16 && frame_wraps == wraps_at_start; chunk++) begin
            repeat (50) command_queue.push_back(frame_sweep_command());
            wait_queue_empty();
        end

        // closing stretch without idling on either side
        wait_replies_done();
        quiet_tail = 1'b1;
        repeat (100) command_queue.push_back(random_command());
        wait_replies_done();
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
